// ===== rtl/put_pkg.sv =====
`default_nettype none

package put_pkg;

	typedef enum logic [1:0] {
		FUNC_TICK  = 2'd0,
		FUNC_READ  = 2'd1,
		FUNC_WRITE = 2'd2
	} func_t;

	localparam int unsigned OFS_W  = 7;
	localparam int unsigned WORD_W = 32;

	localparam logic [OFS_W-1:0] OFS_CTRL   = 7'h00;
	localparam logic [OFS_W-1:0] OFS_IRQEN  = 7'h0c;
	localparam logic [OFS_W-1:0] OFS_STATUS = 7'h10;
	localparam logic [OFS_W-1:0] OFS_GEN    = 7'h14;
	localparam logic [OFS_W-1:0] OFS_COUNT  = 7'h24;
	localparam logic [OFS_W-1:0] OFS_PSC    = 7'h28;
	localparam logic [OFS_W-1:0] OFS_RELOAD = 7'h2c;

	localparam logic [WORD_W-1:0] RELOAD_RESET = 32'h0000_ffff;

	localparam int unsigned CTRL_ENABLE_BIT    = 0;
	localparam int unsigned CTRL_ONE_PULSE_BIT = 3;

	typedef struct packed {
		logic [1:0]        func;
		logic [OFS_W-1:0]  reg_offset;
		logic [WORD_W-1:0] write_data;
		logic [WORD_W-1:0] data_mask;
	} req_t;

	typedef struct packed {
		logic [WORD_W-1:0] read_data;
		logic              update_event;
		logic              update_irq;
	} rsp_t;

endpackage

`default_nettype wire

// ===== rtl/put_if.sv =====
`default_nettype none

interface put_req_if;
	logic        valid;
	logic        ready;
	logic [1:0]  func;
	logic [6:0]  reg_offset;
	logic [31:0] write_data;
	logic [31:0] data_mask;

	modport source (output valid, output func, output reg_offset, output write_data,
		output data_mask, input ready);
	modport sink (input valid, input func, input reg_offset, input write_data,
		input data_mask, output ready);
endinterface

interface put_rsp_if;
	logic        valid;
	logic        ready;
	logic [31:0] read_data;
	logic        update_event;
	logic        update_irq;

	modport source (output valid, output read_data, output update_event,
		output update_irq, input ready);
	modport sink (input valid, input read_data, input update_event,
		input update_irq, output ready);
endinterface

`default_nettype wire

// ===== rtl/prescaled_update_timer.sv =====
// A word accepted is held in the request register, then its result is registered in the result register.
// Throughput: one word per cycle; the request and result registers both
// advance whenever the result register is empty or being taken.
// Reset (arst_n low, asynchronous): registers clear, reload goes to 0xffff,
// request and result registers are emptied.
`default_nettype none

module prescaled_update_timer (
	input wire logic  clk,
	input wire logic  arst_n,
	put_req_if.sink   req,
	put_rsp_if.source rsp
);
	import put_pkg::*;

	logic              valid_s1;
	req_t              req_s1;
	logic              rsp_valid_q;
	rsp_t              rsp_q;

	logic [WORD_W-1:0] ctrl_q, irqen_q, status_q, psc_q, reload_q, count_q, phase_q;
	logic [WORD_W-1:0] ctrl_d, irqen_d, status_d, psc_d, reload_d, count_d, phase_d;
	rsp_t              rsp_d;

	logic advance;
	logic update;

	assign advance   = !rsp_valid_q || rsp.ready;
	assign req.ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (req.ready) begin
			valid_s1 <= req.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (req.ready && req.valid) begin
			req_s1 <= '{func: req.func, reg_offset: req.reg_offset,
				write_data: req.write_data, data_mask: req.data_mask};
		end
	end

	always_comb begin
		ctrl_d   = ctrl_q;
		irqen_d  = irqen_q;
		status_d = status_q;
		psc_d    = psc_q;
		reload_d = reload_q;
		count_d  = count_q;
		phase_d  = phase_q;
		update   = 1'b0;
		rsp_d    = '0;

		case (req_s1.func)
			FUNC_TICK: begin
				if (ctrl_q[CTRL_ENABLE_BIT]) begin
					if (phase_q >= psc_q) begin
						phase_d = '0;
						if (count_q >= reload_q) begin
							update = 1'b1;
						end else begin
							count_d = count_q + 32'd1;
						end
					end else begin
						phase_d = phase_q + 32'd1;
					end
				end
			end
			FUNC_READ: begin
				unique case (req_s1.reg_offset)
					OFS_CTRL:   rsp_d.read_data = ctrl_q;
					OFS_IRQEN:  rsp_d.read_data = irqen_q;
					OFS_STATUS: rsp_d.read_data = status_q;
					OFS_COUNT:  rsp_d.read_data = count_q;
					OFS_PSC:    rsp_d.read_data = psc_q;
					OFS_RELOAD: rsp_d.read_data = reload_q;
					default:    rsp_d.read_data = '0;
				endcase
			end
			FUNC_WRITE: begin
				unique case (req_s1.reg_offset)
					OFS_CTRL: begin
						ctrl_d  = req_s1.write_data;
						phase_d = '0;
					end
					OFS_PSC: begin
						psc_d   = req_s1.write_data;
						phase_d = '0;
					end
					OFS_RELOAD: begin
						reload_d = req_s1.write_data;
						phase_d  = '0;
					end
					OFS_COUNT: begin
						count_d = req_s1.write_data;
						phase_d = '0;
					end
					OFS_IRQEN:  irqen_d = req_s1.write_data;
					// write 0 to clear, bits with data_mask 0 keep their value
					OFS_STATUS: status_d = status_q & (req_s1.write_data | ~req_s1.data_mask);
					OFS_GEN:    update = req_s1.write_data[0] & req_s1.data_mask[0];
					default: ;
				endcase
			end
			default: ;
		endcase

		// update event overrides whatever the tick or write did to these
		if (update) begin
			count_d     = '0;
			phase_d     = '0;
			status_d[0] = 1'b1;
			if (ctrl_q[CTRL_ONE_PULSE_BIT]) begin
				ctrl_d[CTRL_ENABLE_BIT] = 1'b0;
			end
			rsp_d.update_event = 1'b1;
			rsp_d.update_irq   = irqen_q[0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctrl_q      <= '0;
			irqen_q     <= '0;
			status_q    <= '0;
			psc_q       <= '0;
			reload_q    <= RELOAD_RESET;
			count_q     <= '0;
			phase_q     <= '0;
			rsp_valid_q <= 1'b0;
		end else if (advance) begin
			rsp_valid_q <= valid_s1;
			if (valid_s1) begin
				ctrl_q   <= ctrl_d;
				irqen_q  <= irqen_d;
				status_q <= status_d;
				psc_q    <= psc_d;
				reload_q <= reload_d;
				count_q  <= count_d;
				phase_q  <= phase_d;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (advance && valid_s1) begin
			rsp_q <= rsp_d;
		end
	end

	assign rsp.valid        = rsp_valid_q;
	assign rsp.read_data    = rsp_q.read_data;
	assign rsp.update_event = rsp_q.update_event;
	assign rsp.update_irq   = rsp_q.update_irq;

endmodule

`default_nettype wire

// ===== verif/timer_checker.sv =====
`timescale 1ns / 1ps

module timer_checker
	import put_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	put_req_if   req,
	put_rsp_if   rsp,
	output int   mismatches,
	output int   outstanding,
	output int   words_seen,
	output int   reads_seen,
	output int   updates_seen,
	output int   irqs_seen
);

	// shadow copy of the timer registers
	logic [WORD_W-1:0] ctrl_q;
	logic [WORD_W-1:0] irqen_q;
	logic [WORD_W-1:0] status_q;
	logic [WORD_W-1:0] psc_q;
	logic [WORD_W-1:0] reload_q;
	logic [WORD_W-1:0] count_q;
	logic [WORD_W-1:0] phase_q;

	rsp_t due_results[$];
	rsp_t want;
	rsp_t got;

	function automatic void reset_timer();
		ctrl_q   = '0;
		irqen_q  = '0;
		status_q = '0;
		psc_q    = '0;
		reload_q = RELOAD_RESET;
		count_q  = '0;
		phase_q  = '0;
	endfunction

	function automatic void fire_update();
		count_q = '0;
		phase_q = '0;
		status_q[0] = 1'b1;
		if (ctrl_q[CTRL_ONE_PULSE_BIT])
			ctrl_q[CTRL_ENABLE_BIT] = 1'b0;
	endfunction

	function automatic rsp_t next_timer_result(input logic [1:0] f, input logic [OFS_W-1:0] ofs,
		input logic [WORD_W-1:0] d, input logic [WORD_W-1:0] m);
		rsp_t r;
		r = '0;
		case (f)
			FUNC_TICK: begin
				if (ctrl_q[CTRL_ENABLE_BIT]) begin
					if (phase_q >= psc_q) begin
						phase_q = '0;
						if (count_q >= reload_q) begin
							r.update_event = 1'b1;
							r.update_irq = irqen_q[0];
							fire_update();
						end else begin
							count_q = count_q + 32'd1;
						end
					end else begin
						phase_q = phase_q + 32'd1;
					end
				end
			end
			FUNC_READ: begin
				case (ofs)
					OFS_CTRL:   r.read_data = ctrl_q;
					OFS_IRQEN:  r.read_data = irqen_q;
					OFS_STATUS: r.read_data = status_q;
					OFS_COUNT:  r.read_data = count_q;
					OFS_PSC:    r.read_data = psc_q;
					OFS_RELOAD: r.read_data = reload_q;
					default:    r.read_data = '0;
				endcase
			end
			FUNC_WRITE: begin
				case (ofs)
					OFS_CTRL: begin
						ctrl_q = d;
						phase_q = '0;
					end
					OFS_PSC: begin
						psc_q = d;
						phase_q = '0;
					end
					OFS_RELOAD: begin
						reload_q = d;
						phase_q = '0;
					end
					OFS_COUNT: begin
						count_q = d;
						phase_q = '0;
					end
					OFS_IRQEN:  irqen_q = d;
					OFS_STATUS: status_q = status_q & (d | ~m);
					OFS_GEN: begin
						if (d[0] & m[0]) begin
							r.update_event = 1'b1;
							r.update_irq = irqen_q[0];
							fire_update();
						end
					end
					default: ;
				endcase
			end
			default: ;
		endcase
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			reset_timer();
			due_results.delete();
			outstanding = 0;
		end else begin
			if (rsp.valid && rsp.ready) begin
				got.read_data = rsp.read_data;
				got.update_event = rsp.update_event;
				got.update_irq = rsp.update_irq;
				if (due_results.size() == 0) begin
					$display("%0t: unexpected word read_data=%h update_event=%b update_irq=%b",
						$time, got.read_data, got.update_event, got.update_irq);
					mismatches++;
				end else begin
					want = due_results.pop_front();
					if (got.read_data !== want.read_data) begin
						$display("%0t: read_data expected %h got %h",
							$time, want.read_data, got.read_data);
						mismatches++;
					end
					if (got.update_event !== want.update_event) begin
						$display("%0t: update_event expected %b got %b",
							$time, want.update_event, got.update_event);
						mismatches++;
					end
					if (got.update_irq !== want.update_irq) begin
						$display("%0t: update_irq expected %b got %b",
							$time, want.update_irq, got.update_irq);
						mismatches++;
					end
				end
			end
			if (req.valid && req.ready) begin
				want = next_timer_result(req.func, req.reg_offset, req.write_data,
					req.data_mask);
				due_results.insert(due_results.size(), want);
				words_seen++;
				if (req.func == FUNC_READ)
					reads_seen++;
				if (want.update_event)
					updates_seen++;
				if (want.update_irq)
					irqs_seen++;
			end
			outstanding = due_results.size();
		end
	end

endmodule

// ===== verif/tb.sv =====
`timescale 1ns / 1ps

module tb;
	import put_pkg::*;

	localparam logic [1:0] FUNC_NONE = 2'd3;
	localparam int RANDOM_WORDS   = 750;
	localparam int HOLD_CYCLES    = 60;
	localparam int WATCHDOG_LIMIT = 2000;

	logic clk;
	logic arst_n;

	put_req_if req();
	put_rsp_if rsp();

	int mismatches;
	int outstanding;
	int words_seen;
	int reads_seen;
	int updates_seen;
	int irqs_seen;

	int gap_pct;
	int stall_pct;
	bit hold_request;
	int idle_cycles;

	prescaled_update_timer dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req),
		.rsp    (rsp)
	);

	timer_checker chk (
		.clk          (clk),
		.arst_n       (arst_n),
		.req          (req),
		.rsp          (rsp),
		.mismatches   (mismatches),
		.outstanding  (outstanding),
		.words_seen   (words_seen),
		.reads_seen   (reads_seen),
		.updates_seen (updates_seen),
		.irqs_seen    (irqs_seen)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	// stuck detector: cycles with no word moving on either side
	always @(posedge clk) begin
		if (!arst_n || (req.valid && req.ready) || (rsp.valid && rsp.ready)) begin
			idle_cycles <= 0;
		end else if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("%0t: no progress for %0d cycles", $time, idle_cycles);
			$display("[prescaled_update_timer] ERROR");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	// result side back-pressure
	initial begin
		rsp.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (hold_request) begin
				hold_request = 1'b0;
				rsp.ready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
			end else if ($urandom_range(0, 99) < stall_pct) begin
				rsp.ready <= 1'b0;
				repeat ($urandom_range(1, 6)) @(posedge clk);
			end
			rsp.ready <= 1'b1;
		end
	end

	task automatic send_word(input logic [1:0] f, input logic [OFS_W-1:0] ofs,
		input logic [WORD_W-1:0] d, input logic [WORD_W-1:0] m);
		req.valid <= 1'b1;
		req.func <= f;
		req.reg_offset <= ofs;
		req.write_data <= d;
		req.data_mask <= m;
		@(posedge clk);
		while (!req.ready)
			@(posedge clk);
		if ($urandom_range(0, 99) < gap_pct) begin
			req.valid <= 1'b0;
			repeat ($urandom_range(1, 6)) @(posedge clk);
		end
	endtask

	function automatic logic [OFS_W-1:0] pick_reg();
		case ($urandom_range(0, 6))
			0:       return OFS_CTRL;
			1:       return OFS_IRQEN;
			2:       return OFS_STATUS;
			3:       return OFS_GEN;
			4:       return OFS_COUNT;
			5:       return OFS_PSC;
			default: return OFS_RELOAD;
		endcase
	endfunction

	// mostly ticks against small prescale/reload so update events come often
	task automatic send_random_word();
		int pick;
		logic [1:0] f;
		logic [OFS_W-1:0] ofs;
		logic [WORD_W-1:0] d;
		logic [WORD_W-1:0] m;
		pick = $urandom_range(0, 99);
		f = FUNC_TICK;
		ofs = OFS_W'($urandom_range(0, 127));
		d = $urandom;
		m = $urandom;
		if (pick >= 50 && pick < 70) begin
			f = FUNC_READ;
			if (pick < 67)
				ofs = pick_reg();
		end else if (pick >= 70 && pick < 96) begin
			f = FUNC_WRITE;
			if (pick < 94)
				ofs = pick_reg();
			case (ofs)
				OFS_PSC:
					if ($urandom_range(0, 99) < 85)
						d = $urandom_range(0, 3);
				OFS_RELOAD:
					if ($urandom_range(0, 99) < 85)
						d = $urandom_range(0, 9);
				OFS_COUNT:
					if ($urandom_range(0, 99) < 80)
						d = $urandom_range(0, 12);
				OFS_CTRL:
					if ($urandom_range(0, 99) < 80)
						d[CTRL_ENABLE_BIT] = 1'b1;
				OFS_STATUS:
					if ($urandom_range(0, 1) == 0)
						m[0] = 1'b1;
				default: ;
			endcase
		end else if (pick >= 96) begin
			f = FUNC_NONE;
		end
		send_word(f, ofs, d, m);
	endtask

	initial begin
		arst_n <= 1'b0;
		req.valid <= 1'b0;
		req.func <= FUNC_TICK;
		req.reg_offset <= '0;
		req.write_data <= '0;
		req.data_mask <= '0;
		hold_request = 1'b0;
		gap_pct = 15;
		stall_pct = 15;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset values, including the reload default and the write-only generate
		send_word(FUNC_READ, OFS_STATUS, '0, '0);
		send_word(FUNC_READ, OFS_GEN, '0, '0);
		send_word(FUNC_READ, OFS_COUNT, '0, '0);
		send_word(FUNC_READ, OFS_RELOAD, '0, '0);
		// overflow through the prescaler with the interrupt enabled
		send_word(FUNC_WRITE, OFS_PSC, 32'd1, '1);
		send_word(FUNC_WRITE, OFS_RELOAD, 32'd1, '1);
		send_word(FUNC_WRITE, OFS_IRQEN, 32'd1, '1);
		send_word(FUNC_WRITE, OFS_CTRL, 32'd1, '1);
		repeat (4) send_word(FUNC_TICK, '0, '0, '0);
		// status bit 0 survives when masked out, clears when written with 0
		send_word(FUNC_WRITE, OFS_STATUS, '0, 32'hffff_fffe);
		send_word(FUNC_WRITE, OFS_STATUS, '0, '1);
		send_word(FUNC_READ, OFS_STATUS, '0, '0);
		// counter above reload, one-pulse drops the enable
		send_word(FUNC_WRITE, OFS_CTRL, 32'h9, '1);
		send_word(FUNC_WRITE, OFS_COUNT, '1, '1);
		repeat (2) send_word(FUNC_TICK, '0, '0, '0);
		send_word(FUNC_READ, OFS_CTRL, '0, '0);
		// forced update while disabled, then one with bit 0 masked off
		send_word(FUNC_WRITE, OFS_GEN, 32'd1, 32'd1);
		send_word(FUNC_WRITE, OFS_GEN, 32'd1, 32'h0);
		// unaligned and unlisted offsets, unused function code, extreme settings
		send_word(FUNC_WRITE, 7'h01, '1, '1);
		send_word(FUNC_READ, 7'd79, '0, '0);
		send_word(FUNC_NONE, OFS_COUNT, '1, '1);
		send_word(FUNC_WRITE, OFS_PSC, '1, '1);
		send_word(FUNC_WRITE, OFS_RELOAD, '1, '1);

		for (int i = 0; i < RANDOM_WORDS; i++) begin
			case (i)
				0: begin
					gap_pct = 25;
					stall_pct = 25;
				end
				150: hold_request = 1'b1;
				300: begin
					req.valid <= 1'b0;
					do @(negedge clk); while (outstanding != 0);
					@(posedge clk);
				end
				350: begin
					gap_pct = 0;
					stall_pct = 0;
				end
				450: begin
					gap_pct = 35;
					stall_pct = 35;
				end
				600: begin
					gap_pct = 0;
					stall_pct = 0;
				end
				default: ;
			endcase
			send_random_word();
		end
		req.valid <= 1'b0;

		do @(negedge clk); while (outstanding != 0);
		repeat (10) @(posedge clk);

		$display("covered %0d words (%0d reads), %0d update events, %0d interrupt pulses",
			words_seen, reads_seen, updates_seen, irqs_seen);
		if (mismatches == 0 && outstanding == 0)
			$display("[prescaled_update_timer] OK");
		else
			$display("[prescaled_update_timer] ERROR");
		$finish;
	end

endmodule

// ===== sim.f =====
rtl/put_pkg.sv
rtl/put_if.sv
rtl/prescaled_update_timer.sv
verif/timer_checker.sv
verif/tb.sv
